// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/prp_pkg.sv =====
`timescale 1ns / 1ps

package prp_pkg;

   // widths of the travelling records, sized for the largest parameter values
   localparam int IDX_MAX_W  = 4;
   localparam int DIST_MAX_W = 16;
   localparam int AGE_MAX_W  = 4;
   localparam int PAGE_W     = 7;

   localparam logic [1:0] POLICY_OPT  = 2'd0;
   localparam logic [1:0] POLICY_FIFO = 2'd1;
   localparam logic [1:0] POLICY_LRU  = 2'd2;

   localparam logic REG_POLICY = 1'b0;

   // search token passed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic [PAGE_W-1:0]     page;
      logic                  hit;
      logic [IDX_MAX_W-1:0]  hit_idx;
      logic                  free;
      logic [IDX_MAX_W-1:0]  free_idx;
      logic [DIST_MAX_W-1:0] best_dist;
      logic [IDX_MAX_W-1:0]  dist_idx;
      logic [AGE_MAX_W-1:0]  best_age;
      logic [IDX_MAX_W-1:0]  age_idx;
   } scan_type;

   // bookkeeping command broadcast to every cell
   typedef struct packed {
      logic                  valid;
      logic [IDX_MAX_W-1:0]  target;
      logic                  fill;
      logic                  age_all;
      logic [PAGE_W-1:0]     page;
      logic [DIST_MAX_W-1:0] distance;
      logic [AGE_MAX_W-1:0]  old_rank;
   } update_type;

endpackage

// ===== rtl/prp_cell.sv =====
`timescale 1ns / 1ps

module prp_cell import prp_pkg::*; #(
   parameter int IDX = 0,
   parameter int DW  = 10,
   parameter int AW  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  scan_type          scan_in,
   output scan_type          scan_out,
   input  update_type        update,
   output logic [PAGE_W-1:0] page_out,
   output logic [AW-1:0]     age_out
);

   localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

   logic [PAGE_W-1:0] page_ff;
   logic [PAGE_W-1:0] page_in;
   logic              valid_ff;
   logic              valid_in;
   logic [DW-1:0]     dist_ff;
   logic [DW-1:0]     dist_in;
   logic [AW-1:0]     age_ff;
   logic [AW-1:0]     age_in;
   scan_type          scan_ff;
   scan_type          scan_in_next;

   always_comb begin
      scan_in_next = scan_in;
      if (!scan_in.hit && valid_ff && (page_ff == scan_in.page)) begin
         scan_in_next.hit     = 1'b1;
         scan_in_next.hit_idx = MY_IDX;
      end
      if (!scan_in.free && !valid_ff) begin
         scan_in_next.free     = 1'b1;
         scan_in_next.free_idx = MY_IDX;
      end
      if (DIST_MAX_W'(dist_ff) > scan_in.best_dist) begin
         scan_in_next.best_dist = DIST_MAX_W'(dist_ff);
         scan_in_next.dist_idx  = MY_IDX;
      end
      if (AGE_MAX_W'(age_ff) > scan_in.best_age) begin
         scan_in_next.best_age = AGE_MAX_W'(age_ff);
         scan_in_next.age_idx  = MY_IDX;
      end
   end

   always_comb begin
      page_in  = page_ff;
      valid_in = valid_ff;
      dist_in  = dist_ff;
      age_in   = age_ff;
      if (update.valid) begin
         if (update.target == MY_IDX) begin
            age_in  = '0;
            dist_in = DW'(update.distance);
            if (update.fill) begin
               page_in  = update.page;
               valid_in = 1'b1;
            end
         end else if (valid_ff) begin
            if (update.age_all || (AGE_MAX_W'(age_ff) < update.old_rank)) begin
               age_in = age_ff + AW'(1);
            end
            if (dist_ff != '0) begin
               dist_in = dist_ff - DW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         dist_ff  <= '0;
         age_ff   <= '0;
         scan_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         dist_ff  <= dist_in;
         age_ff   <= age_in;
         scan_ff  <= scan_in_next;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign scan_out = scan_ff;
   assign page_out = page_ff;
   assign age_out  = age_ff;

endmodule

// ===== rtl/page_replacement_policy.sv =====
`timescale 1ns / 1ps

// Page replacement unit with a FRAMES-entry frame table and a selectable victim policy
// (optimal next-use, first-in first-out, least recently used). One transaction is in work
// at a time and passes through these steps: acceptance, the page-number division (a
// reciprocal multiply), launch of the search, the search token walking the row of frame
// cells one cell per cycle, and the commit of the bookkeeping, which loads the result
// register. The commit waits while a previous result has not yet been taken; a new request
// can be accepted while a result waits.
module page_replacement_policy import prp_pkg::*; #(
   parameter int FRAMES     = 4,
   parameter int PAGE_WORDS = 10,
   parameter int HORIZON    = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [9:0]  req_address,
   input  logic [9:0]  req_next_use,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_page_number,
   output logic        rsp_hit,
   output logic [1:0]  rsp_frame,
   output logic        rsp_evicted,
   output logic [6:0]  rsp_evicted_page,
   output logic [15:0] rsp_fault_total,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int AW    = IW;
   localparam int DW    = $clog2(HORIZON + 1);
   localparam int SHIFT = 10 + $clog2(PAGE_WORDS);
   localparam int RECIP = ((2 ** SHIFT) + PAGE_WORDS - 1) / PAGE_WORDS;
   localparam int PW    = 10 + SHIFT + 1;
   localparam logic [IW-1:0] LAST_FRAME = IW'(FRAMES - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_INJECT = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;

   logic [2:0]        state_ff;
   logic [2:0]        state_in;
   logic [9:0]        addr_ff;
   logic [DW-1:0]     dist_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [PW-1:0]     product;
   logic [1:0]        policy_ff;
   logic [IW-1:0]     fifo_ff;
   logic [IW-1:0]     fifo_in;
   logic [15:0]       fault_ff;
   logic [15:0]       fault_in;
   logic [IW-1:0]     target_ff;
   logic [IW-1:0]     target_in;
   logic              hit_ff;
   logic              evict_ff;
   logic              evict_in;
   logic              age_all_ff;
   logic              age_all_in;
   logic              commit;
   logic              csr_write;

   logic              rsp_valid_ff;
   logic [6:0]        rsp_page_ff;
   logic              rsp_hit_ff;
   logic [1:0]        rsp_frame_ff;
   logic              rsp_evicted_ff;
   logic [6:0]        rsp_evicted_page_ff;
   logic [15:0]       rsp_fault_ff;

   scan_type          chain [FRAMES+1];
   scan_type          scan_last;
   update_type        update;
   logic [PAGE_W-1:0] pages [FRAMES];
   logic [AW-1:0]     ages  [FRAMES];

   assign req_ready = (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);
   assign product   = PW'(addr_ff) * PW'(RECIP);
   assign scan_last = chain[FRAMES];

   always_comb begin
      chain[0]       = '0;
      chain[0].valid = (state_ff == ST_INJECT);
      chain[0].page  = page_ff;
   end

   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      prp_cell #(
         .IDX (i),
         .DW  (DW),
         .AW  (AW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .scan_in  (chain[i]),
         .scan_out (chain[i+1]),
         .update   (update),
         .page_out (pages[i]),
         .age_out  (ages[i])
      );
   end

   // frame choice (hit, free frame or victim) and fault count once the token has passed every cell
   always_comb begin
      target_in  = target_ff;
      evict_in   = 1'b0;
      age_all_in = 1'b0;
      fifo_in    = fifo_ff;
      fault_in   = fault_ff;
      if (scan_last.hit) begin
         target_in = IW'(scan_last.hit_idx);
      end else begin
         if (fault_ff != '1) begin
            fault_in = fault_ff + 16'd1;
         end
         if (scan_last.free) begin
            target_in  = IW'(scan_last.free_idx);
            age_all_in = 1'b1;
         end else begin
            evict_in = 1'b1;
            case (policy_ff)
               POLICY_OPT: target_in = IW'(scan_last.dist_idx);
               POLICY_LRU: target_in = IW'(scan_last.age_idx);
               default: begin
                  target_in = fifo_ff;
                  fifo_in   = (fifo_ff == LAST_FRAME) ? '0 : fifo_ff + IW'(1);
               end
            endcase
         end
      end
   end

   always_comb begin
      update          = '0;
      update.valid    = commit;
      update.target   = IDX_MAX_W'(target_ff);
      update.fill     = !hit_ff;
      update.age_all  = age_all_ff;
      update.page     = page_ff;
      update.distance = DIST_MAX_W'(dist_ff);
      update.old_rank = AGE_MAX_W'(ages[target_ff]);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DIV;
         ST_DIV:    state_in = ST_INJECT;
         ST_INJECT: state_in = ST_SCAN;
         ST_SCAN:   if (scan_last.valid) state_in = ST_COMMIT;
         ST_COMMIT: if (commit) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POLICY_FIFO;
         fifo_ff      <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            policy_ff <= pwdata[1:0];
         end
         if ((state_ff == ST_SCAN) && scan_last.valid) begin
            fifo_ff  <= fifo_in;
            fault_ff <= fault_in;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         addr_ff <= req_address;
         if (int'(req_next_use) > HORIZON) begin
            dist_ff <= DW'(HORIZON);
         end else begin
            dist_ff <= DW'(req_next_use);
         end
      end
      if (state_ff == ST_DIV) begin
         page_ff <= PAGE_W'(product >> SHIFT);
      end
      if ((state_ff == ST_SCAN) && scan_last.valid) begin
         target_ff  <= target_in;
         hit_ff     <= scan_last.hit;
         evict_ff   <= evict_in;
         age_all_ff <= age_all_in;
      end
      if (commit) begin
         rsp_page_ff         <= page_ff;
         rsp_hit_ff          <= hit_ff;
         rsp_frame_ff        <= 2'(target_ff);
         rsp_evicted_ff      <= evict_ff;
         rsp_evicted_page_ff <= evict_ff ? pages[target_ff] : '0;
         rsp_fault_ff        <= fault_ff;
      end
   end

   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_POLICY);
   assign prdata    = (paddr[2] == REG_POLICY) ? 32'(policy_ff) : '0;
   assign pready    = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_number  = rsp_page_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;
   assign rsp_fault_total  = rsp_fault_ff;

endmodule

// ===== rtl/prp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_page_number,
   input logic        rsp_hit,
   input logic [1:0]  rsp_frame,
   input logic        rsp_evicted,
   input logic [6:0]  rsp_evicted_page,
   input logic [15:0] rsp_fault_total
);

   logic        req_fire;
   logic        rsp_fire;
   logic [1:0]  pending_ff;
   logic [15:0] last_total_ff;
   logic [15:0] next_total;

   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign next_total = (last_total_ff == '1) ? last_total_ff : last_total_ff + 16'd1;

   // transactions accepted but not yet delivered, and the fault total of the last delivered response
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         last_total_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(req_fire) - 2'(rsp_fire);
         if (rsp_fire) begin
            last_total_ff <= rsp_fault_total;
         end
      end
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable({rsp_page_number, rsp_hit, rsp_frame, rsp_evicted,
      rsp_evicted_page, rsp_fault_total}))
   `ASSERT_IMPL(a_no_orphan_rsp, clock, reset, rsp_valid, pending_ff != 2'd0)
   `ASSERT_NEXT(a_one_in_work, clock, reset, req_fire, !req_ready)
   `ASSERT_IMPL(a_hit_total, clock, reset, rsp_fire && rsp_hit,
      rsp_fault_total == last_total_ff)
   `ASSERT_IMPL(a_fault_total, clock, reset, rsp_fire && !rsp_hit,
      rsp_fault_total == next_total)

endmodule

bind page_replacement_policy prp_checker u_prp_checker (.*);
